// ===== sv/lfo_modulated_chorus_core_defines.svh =====
// Assertion macros shared by the chorus core checkers.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef LFO_MODULATED_CHORUS_CORE_DEFINES_SVH
`define LFO_MODULATED_CHORUS_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LMC_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LMC_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lmc_pkg.sv =====
// Shared constants, codes, control structs and constant tables of the chorus core.
// No dependencies; used by lmc_seq, lmc_dp, lfo_modulated_chorus_core and lmc_checker.
package lmc_pkg;

	// Sizes
	localparam int DELAY_DEPTH_DEF = 1024;
	localparam int MAX_VOICES      = 4;
	localparam int SINE_ENTRIES    = 256;
	localparam int SINE_BITS       = $clog2(SINE_ENTRIES);
	localparam int VOICE_W         = $clog2(MAX_VOICES);
	localparam int VCNT_W          = $clog2(MAX_VOICES + 1);

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int INC_W      = 32;
	localparam int PHASE_W    = 32;
	localparam int DEPTH_W    = 9;
	localparam int MIX_W      = 16;
	localparam int VC_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Datapath widths and shifts
	localparam int DLY_W      = DEPTH_W + 1;   // depth*(1+sin) tops out at 1021
	localparam int DELAY_FRAC = 15;
	localparam int ACC_W      = SAMPLE_W + VOICE_W;
	localparam int MUL_W      = 26;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DRY_W      = 33;
	localparam int TERM_W     = 38;
	localparam int SCALE_SH   = 16;
	localparam int BIAS_SH    = 17;            // keeps the pre-divide value positive
	localparam int MB_W       = 21;
	localparam int RECIP_SH   = 24;
	localparam int RECIP_W    = RECIP_SH + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LFO_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOICES  = 2'd3;

	// Register reset values
	localparam logic [INC_W-1:0]   RST_LFO_INC = 32'd146087;
	localparam logic [DEPTH_W-1:0] RST_DEPTH   = 9'd88;
	localparam logic [MIX_W-1:0]   RST_MIX     = 16'd32768;
	localparam logic [VC_W-1:0]    RST_VOICES  = 3'd2;

	// Datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
	localparam logic [OP_W-1:0] OP_PHASE = 4'd2;
	localparam logic [OP_W-1:0] OP_SINE  = 4'd3;
	localparam logic [OP_W-1:0] OP_DMUL  = 4'd4;
	localparam logic [OP_W-1:0] OP_ADDR  = 4'd5;
	localparam logic [OP_W-1:0] OP_ACC   = 4'd6;
	localparam logic [OP_W-1:0] OP_DRY   = 4'd7;
	localparam logic [OP_W-1:0] OP_WET   = 4'd8;
	localparam logic [OP_W-1:0] OP_SUM   = 4'd9;
	localparam logic [OP_W-1:0] OP_RMUL  = 4'd10;
	localparam logic [OP_W-1:0] OP_OUT   = 4'd11;

	// Sequencer jump kinds
	localparam int JMP_W = 2;
	localparam logic [JMP_W-1:0] J_NEXT    = 2'd0;
	localparam logic [JMP_W-1:0] J_WAIT_IN = 2'd1;
	localparam logic [JMP_W-1:0] J_LOOP    = 2'd2;
	localparam logic [JMP_W-1:0] J_FINAL   = 2'd3;

	// Program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
	localparam logic [STEP_W-1:0] ST_PHASE = 4'd1;
	localparam logic [STEP_W-1:0] ST_SINE  = 4'd2;
	localparam logic [STEP_W-1:0] ST_DMUL  = 4'd3;
	localparam logic [STEP_W-1:0] ST_ADDR  = 4'd4;
	localparam logic [STEP_W-1:0] ST_ACC   = 4'd5;
	localparam logic [STEP_W-1:0] ST_DRY   = 4'd6;
	localparam logic [STEP_W-1:0] ST_WET   = 4'd7;
	localparam logic [STEP_W-1:0] ST_SUM   = 4'd8;
	localparam logic [STEP_W-1:0] ST_RMUL  = 4'd9;
	localparam logic [STEP_W-1:0] ST_OUT   = 4'd10;

	// One microcode word
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [JMP_W-1:0]  jmp;
		logic [STEP_W-1:0] target;
	} uword_t;

	// Sequencer to datapath control
	typedef struct packed {
		logic               idle;
		logic [OP_W-1:0]    op;
		logic [VOICE_W-1:0] voice;
	} ctrl_t;

	typedef logic [SINE_ENTRIES-1:0][SAMPLE_W-1:0] sine_tab_t;
	typedef logic [MAX_VOICES-1:0][MAX_VOICES-1:0][PHASE_W-1:0] offset_tab_t;
	typedef logic [MAX_VOICES-1:0][RECIP_W-1:0] recip_tab_t;

	// Q1.15 sine of entry k: quarter-wave fold, Q30 Taylor series, round to Q15
	function automatic logic [SAMPLE_W-1:0] sine_entry(input int k);
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		logic        neg;
		f   = (64'(k) << 32) / SINE_ENTRIES;
		neg = 1'b0;
		if (f >= 64'h8000_0000) begin
			neg = 1'b1;
			f   = f - 64'h8000_0000;
		end
		if (f > 64'h4000_0000)
			f = 64'h8000_0000 - f;
		x  = (f * 64'd3373259426) >> 31;
		x2 = (x * x) >> 30;
		t  = 64'd1073741824;
		t  = 64'd1073741824 - (((x2 * t) >> 30) / 110);
		t  = 64'd1073741824 - (((x2 * t) >> 30) / 72);
		t  = 64'd1073741824 - (((x2 * t) >> 30) / 42);
		t  = 64'd1073741824 - (((x2 * t) >> 30) / 20);
		t  = 64'd1073741824 - (((x2 * t) >> 30) / 6);
		s  = (x * t) >> 30;
		r  = (s + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return neg ? 16'(64'd0 - r) : r[15:0];
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		for (int k = 0; k < SINE_ENTRIES; k++)
			tab[k] = sine_entry(k);
		return tab;
	endfunction

	// Voice phase offsets, floor(i * 2^32 / v)
	localparam logic [PHASE_W-1:0] PH_QUARTER    = 32'h4000_0000;
	localparam logic [PHASE_W-1:0] PH_HALF       = 32'h8000_0000;
	localparam logic [PHASE_W-1:0] PH_3QUARTER   = 32'hC000_0000;
	localparam logic [PHASE_W-1:0] PH_THIRD      = PHASE_W'((64'd1 << 32) / 64'd3);
	localparam logic [PHASE_W-1:0] PH_TWO_THIRDS = PHASE_W'((64'd2 << 32) / 64'd3);

	// Reciprocals ceil(2^RECIP_SH / v): exact floor divide over the biased range
	localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(64'd1 << RECIP_SH);
	localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd1) / 64'd2);
	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);
	localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((64'd1 << RECIP_SH) + 64'd3) / 64'd4);

	localparam sine_tab_t   SINE_ROM   = build_sine();

	// Row v-1, column i
	localparam offset_tab_t OFFSET_TAB = '{
		'{PH_3QUARTER, PH_HALF,       PH_QUARTER, '0},
		'{'0,          PH_TWO_THIRDS, PH_THIRD,   '0},
		'{'0,          '0,            PH_HALF,    '0},
		'{'0,          '0,            '0,         '0}
	};

	// Entry v-1
	localparam recip_tab_t  RECIP_TAB  = '{RECIP_4, RECIP_3, RECIP_2, RECIP_1};

endpackage

// ===== sv/lmc_seq.sv =====
// Microcode sequencer of the chorus core: step counter, program ROM, voice loop.
// Depends on lmc_pkg for opcodes, jump kinds, step codes and structs.
module lmc_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       out_busy,
	input  logic [lmc_pkg::VCNT_W-1:0] v,
	output lmc_pkg::ctrl_t             ctrl
);

	// Program: wait, per-voice tap loop, mix and scale, deliver
	function automatic lmc_pkg::uword_t ucode_rom(input logic [lmc_pkg::STEP_W-1:0] step);
		lmc_pkg::uword_t w;
		case (step)
			lmc_pkg::ST_WAIT:  w = '{lmc_pkg::OP_LOAD,  lmc_pkg::J_WAIT_IN, lmc_pkg::ST_WAIT};
			lmc_pkg::ST_PHASE: w = '{lmc_pkg::OP_PHASE, lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_SINE:  w = '{lmc_pkg::OP_SINE,  lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_DMUL:  w = '{lmc_pkg::OP_DMUL,  lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_ADDR:  w = '{lmc_pkg::OP_ADDR,  lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_ACC:   w = '{lmc_pkg::OP_ACC,   lmc_pkg::J_LOOP,    lmc_pkg::ST_PHASE};
			lmc_pkg::ST_DRY:   w = '{lmc_pkg::OP_DRY,   lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_WET:   w = '{lmc_pkg::OP_WET,   lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_SUM:   w = '{lmc_pkg::OP_SUM,   lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_RMUL:  w = '{lmc_pkg::OP_RMUL,  lmc_pkg::J_NEXT,    lmc_pkg::ST_WAIT};
			lmc_pkg::ST_OUT:   w = '{lmc_pkg::OP_OUT,   lmc_pkg::J_FINAL,   lmc_pkg::ST_WAIT};
			default:           w = '{lmc_pkg::OP_NOP,   lmc_pkg::J_FINAL,   lmc_pkg::ST_WAIT};
		endcase
		return w;
	endfunction

	logic [lmc_pkg::STEP_W-1:0]  step_q;
	logic [lmc_pkg::STEP_W-1:0]  step_nxt;
	logic [lmc_pkg::VOICE_W-1:0] voice_q;
	logic [lmc_pkg::OP_W-1:0]    op_eff;
	logic                        more;
	lmc_pkg::uword_t             uw;

	assign uw   = ucode_rom(step_q);
	assign more = (lmc_pkg::VCNT_W'(voice_q) + lmc_pkg::VCNT_W'(1)) < v;

	// Next step and gated op
	always_comb begin
		op_eff   = uw.op;
		step_nxt = step_q + lmc_pkg::STEP_W'(1);
		case (uw.jmp)
			lmc_pkg::J_WAIT_IN: begin
				if (!in_valid) begin
					op_eff   = lmc_pkg::OP_NOP;
					step_nxt = step_q;
				end
			end
			lmc_pkg::J_LOOP: begin
				if (more)
					step_nxt = uw.target;
			end
			lmc_pkg::J_FINAL: begin
				if (out_busy) begin
					op_eff   = lmc_pkg::OP_NOP;
					step_nxt = step_q;
				end else begin
					step_nxt = uw.target;
				end
			end
			default: begin
			end
		endcase
	end

	// Step counter and voice counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= lmc_pkg::ST_WAIT;
			voice_q <= '0;
		end else begin
			step_q <= step_nxt;
			if (op_eff == lmc_pkg::OP_LOAD)
				voice_q <= '0;
			else if (op_eff == lmc_pkg::OP_ACC && more)
				voice_q <= voice_q + lmc_pkg::VOICE_W'(1);
		end
	end

	assign ctrl.idle  = (uw.jmp == lmc_pkg::J_WAIT_IN);
	assign ctrl.op    = op_eff;
	assign ctrl.voice = voice_q;

endmodule

// ===== sv/lmc_dp.sv =====
// Datapath of the chorus core: delay store, LFO phase, shared multiplier, output register.
// Depends on lmc_pkg for widths, opcodes and the sine, offset and reciprocal tables.
module lmc_dp #(
	parameter int DELAY_DEPTH = lmc_pkg::DELAY_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lmc_pkg::ctrl_t                      ctrl,
	input  logic [lmc_pkg::VCNT_W-1:0]          v,
	input  logic [lmc_pkg::INC_W-1:0]           lfo_increment,
	input  logic [lmc_pkg::DEPTH_W-1:0]         depth_samples,
	input  logic [lmc_pkg::MIX_W-1:0]           mix,
	input  logic signed [lmc_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                out_stall,
	output logic signed [lmc_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                out_valid
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = ((AW > lmc_pkg::DLY_W) ? AW : lmc_pkg::DLY_W) + 1;
	localparam int QW = lmc_pkg::MB_W + 1;
	localparam logic signed [QW-1:0] BIAS_Q = QW'(1 << lmc_pkg::BIAS_SH);
	localparam logic signed [QW-1:0] SAT_HI = QW'(32767);
	localparam logic signed [QW-1:0] SAT_LO = QW'(-32768);

	logic signed [lmc_pkg::SAMPLE_W-1:0] mem [DELAY_DEPTH];

	// Control state
	logic [AW-1:0]               wp_q;
	logic                        full_q;
	logic [lmc_pkg::PHASE_W-1:0] phase_q;
	logic                        out_valid_q;

	// Payload registers
	logic signed [lmc_pkg::SAMPLE_W-1:0] x_q;
	logic signed [lmc_pkg::ACC_W-1:0]    acc_q;
	logic [lmc_pkg::PHASE_W-1:0]         p_q;
	logic signed [lmc_pkg::SAMPLE_W-1:0] s_q;
	logic signed [lmc_pkg::PROD_W-1:0]   mul_q;
	logic signed [lmc_pkg::SAMPLE_W-1:0] rd_q;
	logic                                rvalid_q;
	logic signed [lmc_pkg::TERM_W-1:0]   term_q;
	logic [lmc_pkg::MB_W-1:0]            mb_q;
	logic signed [lmc_pkg::SAMPLE_W-1:0] out_q;

	logic [lmc_pkg::VCNT_W-1:0]          vm1;
	logic signed [lmc_pkg::MUL_W-1:0]    mul_a;
	logic signed [lmc_pkg::MUL_W-1:0]    mul_b;
	logic [CW-1:0]                       dly_raw;
	logic [CW-1:0]                       dly;
	logic [CW-1:0]                       wp_ext;
	logic [CW-1:0]                       rp_ext;
	logic [AW-1:0]                       rp;
	logic                                tap_ok;
	logic signed [lmc_pkg::SAMPLE_W-1:0] tap;
	logic signed [lmc_pkg::TERM_W-1:0]   v_ext;
	logic signed [lmc_pkg::TERM_W-1:0]   dry_v;
	logic signed [lmc_pkg::TERM_W-1:0]   nsum;
	logic signed [lmc_pkg::TERM_W-1:0]   mshift;
	logic signed [lmc_pkg::TERM_W-1:0]   mb_full;
	logic signed [QW-1:0]                q_full;
	logic signed [lmc_pkg::SAMPLE_W-1:0] q_sat;

	assign vm1   = v - lmc_pkg::VCNT_W'(1);
	assign v_ext = $signed(lmc_pkg::TERM_W'(v));

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			lmc_pkg::OP_DMUL: begin
				mul_a = $signed(lmc_pkg::MUL_W'(depth_samples));
				mul_b = lmc_pkg::MUL_W'(s_q) + (lmc_pkg::MUL_W'(1) <<< lmc_pkg::DELAY_FRAC);
			end
			lmc_pkg::OP_DRY: begin
				mul_a = lmc_pkg::MUL_W'(x_q);
				mul_b = (lmc_pkg::MUL_W'(1) <<< lmc_pkg::MIX_W) - $signed(lmc_pkg::MUL_W'(mix));
			end
			lmc_pkg::OP_WET: begin
				mul_a = lmc_pkg::MUL_W'(acc_q);
				mul_b = $signed(lmc_pkg::MUL_W'(mix));
			end
			lmc_pkg::OP_RMUL: begin
				mul_a = $signed(lmc_pkg::MUL_W'(mb_q));
				mul_b = $signed(lmc_pkg::MUL_W'(lmc_pkg::RECIP_TAB[vm1[lmc_pkg::VOICE_W-1:0]]));
			end
			default: begin
			end
		endcase
	end

	// Tap address: delay clamped to the store, wrapped behind the write pointer
	always_comb begin
		dly_raw = CW'(mul_q[lmc_pkg::DELAY_FRAC +: lmc_pkg::DLY_W]);
		dly     = (dly_raw > CW'(DELAY_DEPTH - 1)) ? CW'(DELAY_DEPTH - 1) : dly_raw;
		wp_ext  = CW'(wp_q);
		tap_ok  = dly <= wp_ext;
		rp_ext  = tap_ok ? (wp_ext - dly) : (wp_ext + CW'(DELAY_DEPTH) - dly);
		rp      = rp_ext[AW-1:0];
	end

	// Unwritten entries read as zero: written iff store has wrapped or rp is at or behind wp
	assign tap = rvalid_q ? rd_q : '0;

	// Dry term times voices plus rounding half, then full sum and biased scale
	always_comb begin
		dry_v   = $signed(mul_q[lmc_pkg::DRY_W-1:0]) * $signed({1'b0, v})
			+ (v_ext <<< (lmc_pkg::SCALE_SH - 1));
		nsum    = term_q + $signed(mul_q[lmc_pkg::TERM_W-1:0]);
		mshift  = nsum >>> lmc_pkg::SCALE_SH;
		mb_full = mshift + (v_ext <<< lmc_pkg::BIAS_SH);
	end

	// Remove bias and saturate
	always_comb begin
		q_full = $signed({1'b0, mul_q[lmc_pkg::RECIP_SH +: lmc_pkg::MB_W]}) - BIAS_Q;
		if (q_full > SAT_HI)
			q_full = SAT_HI;
		else if (q_full < SAT_LO)
			q_full = SAT_LO;
		q_sat = q_full[lmc_pkg::SAMPLE_W-1:0];
	end

	// Delay store: one write on request, one registered tap read
	always_ff @(posedge clk) begin
		if (ctrl.op == lmc_pkg::OP_LOAD)
			mem[wp_q] <= sample_in;
		if (ctrl.op == lmc_pkg::OP_ADDR)
			rd_q <= mem[rp];
	end

	// Payload steps
	always_ff @(posedge clk) begin
		case (ctrl.op)
			lmc_pkg::OP_LOAD: begin
				x_q   <= sample_in;
				acc_q <= '0;
			end
			lmc_pkg::OP_PHASE:
				p_q <= phase_q
					+ lmc_pkg::OFFSET_TAB[vm1[lmc_pkg::VOICE_W-1:0]][ctrl.voice];
			lmc_pkg::OP_SINE:
				s_q <= $signed(lmc_pkg::SINE_ROM[p_q[lmc_pkg::PHASE_W-1 -: lmc_pkg::SINE_BITS]]);
			lmc_pkg::OP_DMUL:
				mul_q <= mul_a * mul_b;
			lmc_pkg::OP_ADDR:
				rvalid_q <= full_q || tap_ok;
			lmc_pkg::OP_ACC:
				acc_q <= acc_q + lmc_pkg::ACC_W'(tap);
			lmc_pkg::OP_DRY:
				mul_q <= mul_a * mul_b;
			lmc_pkg::OP_WET: begin
				term_q <= dry_v;
				mul_q  <= mul_a * mul_b;
			end
			lmc_pkg::OP_SUM:
				mb_q <= mb_full[lmc_pkg::MB_W-1:0];
			lmc_pkg::OP_RMUL:
				mul_q <= mul_a * mul_b;
			lmc_pkg::OP_OUT:
				out_q <= q_sat;
			default: begin
			end
		endcase
	end

	// Pointer, phase, fill flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			full_q      <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (ctrl.op == lmc_pkg::OP_OUT) begin
			out_valid_q <= 1'b1;
			phase_q     <= phase_q + lfo_increment;
			if (wp_q == AW'(DELAY_DEPTH - 1)) begin
				wp_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample_out = out_q;
	assign out_valid  = out_valid_q;

endmodule

// ===== sv/lfo_modulated_chorus_core.sv =====
// Multi-voice chorus core: LFO-modulated delay taps mixed with the dry sample.
// Input channel: in_valid / in_stall carry sample_in (signed Q1.15). A request is
// taken when in_valid is high and in_stall is low; one request is worked at a time.
// Output channel: out_valid / out_stall carry sample_out (signed Q1.15, saturated),
// exactly one result per request, held in an output register.
// Each request runs the microcoded tap loop for V = effective voice count (1..4),
// five steps per voice on the shared multiplier and the single delay store read port,
// then the dry, wet, sum, scale and output steps. A new request is taken while an
// earlier result still waits; if that result is still stalled when the next one is
// ready, the sequencer holds at its last step. Reset clears the LFO phase, write
// pointer and fill flag and loads the register defaults; the delay store is not
// swept: taps behind the fill point read as zero. Config: cfg_we / cfg_index /
// cfg_data write one register per cycle; the user must write only while idle, as
// the block itself does not enforce it. Depends on lmc_pkg, lmc_seq and lmc_dp.
module lfo_modulated_chorus_core #(
	parameter int DELAY_DEPTH = lmc_pkg::DELAY_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lmc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lmc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [lmc_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [lmc_pkg::SAMPLE_W-1:0]   sample_out
);

	logic [lmc_pkg::INC_W-1:0]   lfo_inc_q;
	logic [lmc_pkg::DEPTH_W-1:0] depth_q;
	logic [lmc_pkg::MIX_W-1:0]   mix_q;
	logic [lmc_pkg::VC_W-1:0]    voices_q;
	logic [lmc_pkg::VCNT_W-1:0]  v_eff;
	lmc_pkg::ctrl_t              ctrl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_inc_q <= lmc_pkg::RST_LFO_INC;
			depth_q   <= lmc_pkg::RST_DEPTH;
			mix_q     <= lmc_pkg::RST_MIX;
			voices_q  <= lmc_pkg::RST_VOICES;
		end else if (cfg_we) begin
			case (cfg_index)
				lmc_pkg::REG_LFO_INC: lfo_inc_q <= cfg_data[lmc_pkg::INC_W-1:0];
				lmc_pkg::REG_DEPTH:   depth_q   <= cfg_data[lmc_pkg::DEPTH_W-1:0];
				lmc_pkg::REG_MIX:     mix_q     <= cfg_data[lmc_pkg::MIX_W-1:0];
				lmc_pkg::REG_VOICES:  voices_q  <= cfg_data[lmc_pkg::VC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Voice count clamped to 1..MAX_VOICES
	always_comb begin
		if (voices_q == '0)
			v_eff = lmc_pkg::VCNT_W'(1);
		else if ({1'b0, voices_q} > (lmc_pkg::VC_W + 1)'(lmc_pkg::MAX_VOICES))
			v_eff = lmc_pkg::VCNT_W'(lmc_pkg::MAX_VOICES);
		else
			v_eff = lmc_pkg::VCNT_W'(voices_q);
	end

	lmc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_valid && out_stall),
		.v        (v_eff),
		.ctrl     (ctrl)
	);

	lmc_dp #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.v             (v_eff),
		.lfo_increment (lfo_inc_q),
		.depth_samples (depth_q),
		.mix           (mix_q),
		.sample_in     (sample_in),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.out_valid     (out_valid)
	);

	assign in_stall = !ctrl.idle;

endmodule

// ===== sv/lmc_checker.sv =====
// Port-level checks of the chorus core, attached to the top level by bind.
// Depends on lmc_pkg, lfo_modulated_chorus_core_defines.svh and lfo_modulated_chorus_core.
`include "lfo_modulated_chorus_core_defines.svh"

module lmc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [lmc_pkg::SAMPLE_W-1:0] sample_out
);

	// A stalled result stays offered
	`LMC_CHK_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid, "out_valid dropped under stall")
	// A stalled result does not change
	`LMC_CHK_NEXT(a_out_data_hold, out_valid && out_stall, $stable(sample_out), "sample_out changed under stall")
	// One request in flight: stall goes up right after an accept
	`LMC_CHK_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken while busy")
	// A fresh result appears only as the sequencer returns to waiting
	`LMC_CHK_SAME(a_result_at_idle, $rose(out_valid), !in_stall, "result shown while still busy")

endmodule

bind lfo_modulated_chorus_core lmc_checker u_lmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out)
);
